### hw/rtl/icmb_pkg.sv
`default_nettype none

package icmb_pkg;

    // Cube and palette limits.
    localparam int MAX_BITS   = 5;
    localparam int MAX_COLORS = 256;
    localparam int CELL_AW    = 3 * MAX_BITS;
    localparam int CELL_DEPTH = 1 << CELL_AW;
    localparam int CH_W       = MAX_BITS;
    localparam int SQ_W       = 16;
    localparam int DIST_W     = 18;
    localparam int INDEX_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int BITS_W     = 3;
    localparam int TOTAL_W    = 4;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Item function codes.
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_RED_BITS   = 2'd0;
    localparam logic [1:0] REG_GREEN_BITS = 2'd1;
    localparam logic [1:0] REG_BLUE_BITS  = 2'd2;

    // One map cell as kept in memory.
    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [INDEX_W-1:0] index;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    // Clamp a bit count register into the usable range.
    function automatic logic [BITS_W-1:0] eff_bits(input logic [BITS_W-1:0] v);
        logic [BITS_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = BITS_W'(1);
            end
            else if (v > BITS_W'(MAX_BITS))
            begin
                r = BITS_W'(MAX_BITS);
            end
            return r;
        end
    endfunction

    // Largest channel index for a given bit count.
    function automatic logic [CH_W-1:0] ch_max(input logic [BITS_W-1:0] bits);
        logic [CH_W:0] one_hot;
        begin
            one_hot = (CH_W+1)'(1) << bits;
            return CH_W'(one_hot - (CH_W+1)'(1));
        end
    endfunction

    // Squared distance from the centre of a cell to one colour component.
    // The centre is c*x + x/2 with x = 2^(8-bits); it always fits in 8 bits.
    function automatic logic [SQ_W-1:0] sq_diff(
        input logic [CH_W-1:0]   c,
        input logic [BITS_W-1:0] bits,
        input logic [7:0]        colour
    );
        logic [3:0]  sh;
        logic [11:0] base;
        logic [11:0] half;
        logic [7:0]  centre;
        logic [8:0]  diff;
        logic [8:0]  mag;
        begin
            sh     = 4'(4'd8 - 4'(bits));
            base   = 12'(c) << sh;
            half   = 12'(1) << (sh - 4'd1);
            centre = 8'(base | half);
            diff   = {1'b0, colour} - {1'b0, centre};
            mag    = diff[8] ? (~diff + 9'd1) : diff;
            return SQ_W'(mag[7:0]) * SQ_W'(mag[7:0]);
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/icmb_ram.sv
`default_nettype none

module icmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/inverse_colormap_builder_core.sv
// Beats: a read beat reads its cell when it is taken, and the response state
// hands the index on; a clear beat rewrites all 32768 cells; an add beat sweeps
// 2^(r+g+b) cells and then drains. Throughput: one beat at a time, bounded by
// the single map memory port pair that the sweep walks one cell per cycle.
// Reset: asynchronous, active low; afterwards a clearing pass over all cells runs
// before the first beat is taken. Configuration writes are accepted at any time.
`default_nettype none

module inverse_colormap_builder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [2:0]  cfg_data,
    // Item channel.
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire logic [14:0] cell_address,
    // Result channel.
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [7:0]       map_index
);

    // The block is a small sequencer around one map memory. The memory holds,
    // for every cell of the cube, the best squared distance seen so far and the
    // palette index that produced it. Clearing and adding both sweep the memory
    // one cell per cycle. The add sweep is a two-stage loop: the first stage
    // reads the cell and forms the three per-channel squares, the second adds
    // them, compares against the stored distance and writes back on a strict
    // improvement. Each cell is visited once per sweep, so the write of one
    // cell never races the read of another.

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_DRAIN,
        ST_RESP
    } state_t;

    localparam int AW = icmb_pkg::CELL_AW;
    localparam int CW = icmb_pkg::CH_W;
    localparam int BW = icmb_pkg::BITS_W;

    state_t state_reg, state_next;

    logic [BW-1:0] red_bits_reg, red_bits_next;
    logic [BW-1:0] green_bits_reg, green_bits_next;
    logic [BW-1:0] blue_bits_reg, blue_bits_next;

    logic [icmb_pkg::COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic [AW-1:0]                addr_cnt_reg, addr_cnt_next;
    logic [CW-1:0]                ri_reg, ri_next;
    logic [CW-1:0]                gi_reg, gi_next;
    logic [CW-1:0]                bi_reg, bi_next;
    logic                         s1_valid_reg, s1_valid_next;
    logic                         result_valid_reg, result_valid_next;
    logic [icmb_pkg::INDEX_W-1:0] map_index_reg, map_index_next;

    // Sweep payload, no reset needed.
    logic [7:0]                red_reg, green_reg, blue_reg;
    logic [AW-1:0]             s1_addr_reg;
    logic [icmb_pkg::SQ_W-1:0] sq_r_reg, sq_g_reg, sq_b_reg;

    // Effective bit counts and derived masks.
    logic [BW-1:0]                rb, gb, bb;
    logic [CW-1:0]                r_max, g_max, b_max;
    logic [icmb_pkg::TOTAL_W-1:0] total_bits;
    logic [AW:0]                  addr_span;
    logic [AW-1:0]                addr_mask;

    logic accept;
    logic last_cell;
    logic sweep_step;

    // Memory ports.
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    icmb_pkg::cell_t ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    icmb_pkg::cell_t ram_rdata;

    logic [icmb_pkg::DIST_W-1:0] s2_dist;
    logic                        s2_better;

    assign rb = icmb_pkg::eff_bits(red_bits_reg);
    assign gb = icmb_pkg::eff_bits(green_bits_reg);
    assign bb = icmb_pkg::eff_bits(blue_bits_reg);

    assign r_max = icmb_pkg::ch_max(rb);
    assign g_max = icmb_pkg::ch_max(gb);
    assign b_max = icmb_pkg::ch_max(bb);

    assign total_bits = icmb_pkg::TOTAL_W'(rb) + icmb_pkg::TOTAL_W'(gb)
                      + icmb_pkg::TOTAL_W'(bb);
    assign addr_span  = (AW+1)'(1) << total_bits;
    assign addr_mask  = AW'(addr_span - (AW+1)'(1));

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign map_index    = map_index_reg;

    // The nested red/green/blue walk visits packed addresses in plain order,
    // so a linear counter runs alongside the three channel counters.
    assign last_cell  = (ri_reg == r_max) && (gi_reg == g_max) && (bi_reg == b_max);
    assign sweep_step = (state_reg == ST_ADD);

    // Second stage of the add sweep: total distance and the strict compare.
    // The sum never exceeds 3 * 255^2, so it fits the stored width as is.
    assign s2_dist   = icmb_pkg::DIST_W'(sq_r_reg) + icmb_pkg::DIST_W'(sq_g_reg)
                     + icmb_pkg::DIST_W'(sq_b_reg);
    assign s2_better = s1_valid_reg && (s2_dist < ram_rdata.distance);

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = addr_cnt_reg;
        if (sweep_step)
        begin
            ram_re = 1'b1;
        end
        else if (accept && (func == icmb_pkg::FUNC_READ))
        begin
            ram_re    = 1'b1;
            ram_raddr = cell_address & addr_mask;
        end
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we             = 1'b1;
            ram_waddr          = addr_cnt_reg;
            ram_wdata.distance = icmb_pkg::DIST_MAX;
            ram_wdata.index    = '0;
        end
        else
        begin
            ram_we             = s2_better;
            ram_waddr          = s1_addr_reg;
            ram_wdata.distance = s2_dist;
            ram_wdata.index    = entry_count_reg[icmb_pkg::INDEX_W-1:0];
        end
    end

    icmb_ram #(
        .WIDTH (icmb_pkg::CELL_W),
        .DEPTH (icmb_pkg::CELL_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        red_bits_next     = red_bits_reg;
        green_bits_next   = green_bits_reg;
        blue_bits_next    = blue_bits_reg;
        entry_count_next  = entry_count_reg;
        addr_cnt_next     = addr_cnt_reg;
        ri_next           = ri_reg;
        gi_next           = gi_reg;
        bi_next           = bi_reg;
        s1_valid_next     = 1'b0;
        result_valid_next = result_valid_reg;
        map_index_next    = map_index_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                icmb_pkg::REG_RED_BITS:   red_bits_next   = cfg_data;
                icmb_pkg::REG_GREEN_BITS: green_bits_next = cfg_data;
                icmb_pkg::REG_BLUE_BITS:  blue_bits_next  = cfg_data;
                default:                  ;
            endcase
        end

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                addr_cnt_next = addr_cnt_reg + AW'(1);
                if (addr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                addr_cnt_next = '0;
                ri_next       = '0;
                gi_next       = '0;
                bi_next       = '0;
                if (accept)
                begin
                    unique case (func)
                        icmb_pkg::FUNC_CLEAR:
                        begin
                            entry_count_next = '0;
                            state_next       = ST_CLEAR;
                        end
                        icmb_pkg::FUNC_ADD:
                        begin
                            if (entry_count_reg < icmb_pkg::COUNT_W'(icmb_pkg::MAX_COLORS))
                            begin
                                state_next = ST_ADD;
                            end
                        end
                        icmb_pkg::FUNC_READ:
                        begin
                            state_next = ST_RESP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD:
            begin
                s1_valid_next = 1'b1;
                addr_cnt_next = addr_cnt_reg + AW'(1);
                if (bi_reg == b_max)
                begin
                    bi_next = '0;
                    if (gi_reg == g_max)
                    begin
                        gi_next = '0;
                        ri_next = ri_reg + CW'(1);
                    end
                    else
                    begin
                        gi_next = gi_reg + CW'(1);
                    end
                end
                else
                begin
                    bi_next = bi_reg + CW'(1);
                end
                if (last_cell)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last cell is written back in this cycle.
                entry_count_next = entry_count_reg + icmb_pkg::COUNT_W'(1);
                state_next       = ST_IDLE;
            end
            ST_RESP:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    map_index_next    = ram_rdata.index;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            red_bits_reg     <= BW'(icmb_pkg::MAX_BITS);
            green_bits_reg   <= BW'(icmb_pkg::MAX_BITS);
            blue_bits_reg    <= BW'(icmb_pkg::MAX_BITS);
            entry_count_reg  <= '0;
            addr_cnt_reg     <= '0;
            ri_reg           <= '0;
            gi_reg           <= '0;
            bi_reg           <= '0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            map_index_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            red_bits_reg     <= red_bits_next;
            green_bits_reg   <= green_bits_next;
            blue_bits_reg    <= blue_bits_next;
            entry_count_reg  <= entry_count_next;
            addr_cnt_reg     <= addr_cnt_next;
            ri_reg           <= ri_next;
            gi_reg           <= gi_next;
            bi_reg           <= bi_next;
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            map_index_reg    <= map_index_next;
        end
    end

    // Colour capture and the first sweep stage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
        s1_addr_reg <= addr_cnt_reg;
        sq_r_reg    <= icmb_pkg::sq_diff(ri_reg, rb, red_reg);
        sq_g_reg    <= icmb_pkg::sq_diff(gi_reg, gb, green_reg);
        sq_b_reg    <= icmb_pkg::sq_diff(bi_reg, bb, blue_reg);
    end

    // A result only appears after the response state has fetched it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result raised outside the response state");

    // The palette counter never passes the palette size.
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= icmb_pkg::COUNT_W'(icmb_pkg::MAX_COLORS))
        else $error("palette entry count overflow");

    // Within a sweep the write-back never hits the cell being read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("map memory read and write collide");

    // Memory writes come only from the clearing pass or a pending compare.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_CLEAR) || s1_valid_reg))
        else $error("unexpected map memory write");

endmodule

`default_nettype wire
